### rtl/tet_pkg.sv
// ----------------------------------------------------------------------------
// Terminal tokenizer package
// Token layout, token kinds, byte codes and small helper functions.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam logic [2:0] KIND_GRAPHIC = 3'd0;
  localparam logic [2:0] KIND_CONTROL = 3'd1;
  localparam logic [2:0] KIND_ESC     = 3'd2;
  localparam logic [2:0] KIND_CSI     = 3'd3;
  localparam logic [2:0] KIND_PARAM   = 3'd4;
  localparam logic [2:0] KIND_STRING  = 3'd5;

  localparam logic [1:0] STR_NONE  = 2'd0;
  localparam logic [1:0] STR_OSC   = 2'd1;
  localparam logic [1:0] STR_DCS   = 2'd2;
  localparam logic [1:0] STR_OTHER = 2'd3;

  localparam logic [7:0] B_BS   = 8'h08;
  localparam logic [7:0] B_TAB  = 8'h09;
  localparam logic [7:0] B_LF   = 8'h0a;
  localparam logic [7:0] B_CR   = 8'h0d;
  localparam logic [7:0] B_BEL  = 8'h07;
  localparam logic [7:0] B_CAN  = 8'h18;
  localparam logic [7:0] B_SUB  = 8'h1a;
  localparam logic [7:0] B_ESC  = 8'h1b;
  localparam logic [7:0] B_DEL  = 8'h7f;
  localparam logic [7:0] B_CSI  = 8'h5b;  // '['
  localparam logic [7:0] B_OSC  = 8'h5d;  // ']'
  localparam logic [7:0] B_DCS  = 8'h50;  // 'P'
  localparam logic [7:0] B_SOS  = 8'h58;  // 'X'
  localparam logic [7:0] B_PM   = 8'h5e;  // '^'
  localparam logic [7:0] B_APC  = 8'h5f;  // '_'
  localparam logic [7:0] B_G0   = 8'h28;
  localparam logic [7:0] B_G1   = 8'h29;
  localparam logic [7:0] B_G2   = 8'h2a;
  localparam logic [7:0] B_G3   = 8'h2b;
  localparam logic [7:0] B_RIS  = 8'h63;  // 'c'
  localparam logic [7:0] B_ST   = 8'h5c;  // backslash
  localparam logic [7:0] B_SEMI = 8'h3b;
  localparam logic [7:0] B_COLON = 8'h3a;
  localparam logic [7:0] B_ZERO = 8'h30;
  localparam logic [7:0] B_NINE = 8'h39;
  localparam logic [7:0] B_INTERM_ALL = 8'hff;

  localparam logic [20:0] CP_REPLACE = 21'h00fffd;
  localparam logic [20:0] CP_MAX     = 21'h10ffff;
  localparam logic [20:0] CP_SUR_LO  = 21'h00d800;
  localparam logic [20:0] CP_SUR_HI  = 21'h00dfff;
  localparam logic [13:0] PARAM_SAT  = 14'd9999;

  typedef struct packed {
    logic [2:0]  kind;
    logic [20:0] symbol;
    logic [7:0]  marker;
    logic [7:0]  inter;
    logic [4:0]  total;
    logic [13:0] value;
    logic [7:0]  sep;
    logic [1:0]  stype;
    logic        send;
    logic        sover;
  } tok_t;

  function automatic tok_t mk_tok(logic [2:0] kind, logic [20:0] sym);
    tok_t t;
    t        = '0;
    t.kind   = kind;
    t.symbol = sym;
    return t;
  endfunction

  function automatic logic is_zero_width(logic [20:0] cp);
    return (cp == 21'h200b) || (cp == 21'h200c) || (cp == 21'h200d) ||
           (cp == 21'hfe0e) || (cp == 21'hfe0f);
  endfunction

endpackage

### rtl/tet_in_if.sv
// ----------------------------------------------------------------------------
// Tokenizer input channel
// Valid/ready channel that carries one stream byte per beat.
// ----------------------------------------------------------------------------
interface tet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/tet_out_if.sv
// ----------------------------------------------------------------------------
// Tokenizer result channel
// Valid/ready channel that carries one token per beat.
// ----------------------------------------------------------------------------
interface tet_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [20:0] symbol;
  logic [7:0]  marker_byte;
  logic [7:0]  intermediate_byte;
  logic [4:0]  param_total;
  logic [13:0] param_value;
  logic [7:0]  param_separator;
  logic [1:0]  string_type;
  logic        string_end;
  logic        string_overflowed;
  logic        last;

  modport source (output valid, output token_kind, output symbol, output marker_byte,
                  output intermediate_byte, output param_total, output param_value,
                  output param_separator, output string_type, output string_end,
                  output string_overflowed, output last, input ready);
  modport sink (input valid, input token_kind, input symbol, input marker_byte,
                input intermediate_byte, input param_total, input param_value,
                input param_separator, input string_type, input string_end,
                input string_overflowed, input last, output ready);
endinterface

### rtl/terminal_escape_sequence_tokenizer.sv
// ----------------------------------------------------------------------------
// Terminal escape sequence tokenizer
// Turns a terminal byte stream into graphic, control, escape, CSI, parameter
// and string tokens.
// ----------------------------------------------------------------------------
// One byte is taken per beat on the input channel and turned into zero, one or
// more tokens on the result channel; the final token of each byte carries last.
// A byte is accepted whenever the parser is idle and the output register is
// empty or being drained. A byte that breaks a UTF-8 sequence can cause two
// tokens (a replacement character and the token of the byte itself), and the
// second is sent from its own state, in which no byte is accepted. A CSI final
// byte emits the dispatch token and then one token per collected parameter;
// the parameters sit in a small synchronous memory with a registered read
// port, so each parameter is first read (S_PRD) and then emitted (S_PEMIT),
// and no byte is accepted during the run. Parameters are written to the
// memory only when they are closed by a separator or by the final byte, so
// the memory needs no clearing pass and no valid bits: every entry below the
// parameter count has been written during the current sequence.
// ----------------------------------------------------------------------------
module terminal_escape_sequence_tokenizer #(
  parameter int MAX_PARAMETERS  = 16,
  parameter int STRING_CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  tet_in_if.sink       in_bus,
  tet_out_if.source    out_bus
);

  localparam int IDX_W = $clog2(MAX_PARAMETERS + 1);
  localparam int AW    = (MAX_PARAMETERS > 1) ? $clog2(MAX_PARAMETERS) : 1;
  localparam int LEN_W = $clog2(STRING_CAPACITY + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PARAMETERS);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(STRING_CAPACITY);

  typedef enum logic [2:0] {
    M_GROUND, M_ESCAPE, M_CHARSET, M_CSI, M_STRING, M_STRING_ESC
  } mode_t;

  typedef enum logic [1:0] {S_IDLE, S_EXTRA, S_PRD, S_PEMIT} state_t;

  // Parameter memory entry: value and the separator that preceded it.
  typedef struct packed {
    logic [13:0] value;
    logic [7:0]  sep;
  } pent_t;

  pent_t mem [MAX_PARAMETERS];
  pent_t rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  pent_t         mem_wdata;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [16:0] floor_r, floor_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic        popen_r, popen_nxt;
  logic [13:0] cval_r, cval_nxt;
  logic [7:0]  csep_r, csep_nxt;
  logic [7:0]  psep_r, psep_nxt;
  logic [7:0]  priv_r, priv_nxt;
  logic [7:0]  inter_r, inter_nxt;
  logic [1:0]  sclass_r, sclass_nxt;
  logic [LEN_W-1:0] slen_r, slen_nxt;
  logic        sover_r, sover_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] total_r, total_nxt;
  tet_pkg::tok_t extra_r, extra_nxt;
  tet_pkg::tok_t otok_r, otok_nxt;
  logic        olast_r, olast_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic out_free;
  logic accept;
  logic [7:0] b;

  // Ground handling of a byte with no UTF-8 sequence open.
  logic g0_esc, g0_tv, g0_lead;
  tet_pkg::tok_t g0_tok;
  logic [20:0] g0_acc;
  logic [16:0] g0_floor;
  logic [1:0]  g0_pend;

  assign out_free     = !ovalid_r || out_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE) && out_free;
  assign accept       = in_bus.valid && in_bus.ready;
  assign b            = in_bus.in_byte;

  always_comb begin
    g0_esc   = 1'b0;
    g0_tv    = 1'b0;
    g0_lead  = 1'b0;
    g0_tok   = '0;
    g0_acc   = '0;
    g0_floor = '0;
    g0_pend  = '0;
    if (!b[7]) begin
      if (b == tet_pkg::B_ESC) begin
        g0_esc = 1'b1;
      end else if (b == tet_pkg::B_LF || b == tet_pkg::B_CR ||
                   b == tet_pkg::B_BS || b == tet_pkg::B_TAB) begin
        g0_tv  = 1'b1;
        g0_tok = tet_pkg::mk_tok(tet_pkg::KIND_CONTROL, {13'd0, b});
      end else if (b >= 8'h20 && b != tet_pkg::B_DEL) begin
        g0_tv  = 1'b1;
        g0_tok = tet_pkg::mk_tok(tet_pkg::KIND_GRAPHIC, {13'd0, b});
      end
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      g0_lead  = 1'b1;
      g0_acc   = {16'd0, b[4:0]};
      g0_floor = 17'h00080;
      g0_pend  = 2'd1;
    end else if (b >= 8'he0 && b <= 8'hef) begin
      g0_lead  = 1'b1;
      g0_acc   = {17'd0, b[3:0]};
      g0_floor = 17'h00800;
      g0_pend  = 2'd2;
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      g0_lead  = 1'b1;
      g0_acc   = {18'd0, b[2:0]};
      g0_floor = 17'h10000;
      g0_pend  = 2'd3;
    end else begin
      g0_tv  = 1'b1;
      g0_tok = tet_pkg::mk_tok(tet_pkg::KIND_GRAPHIC, tet_pkg::CP_REPLACE);
    end
  end

  // Main next-state logic.
  logic          t1v, t2v, disp;
  tet_pkg::tok_t t1, t2;
  logic [20:0]   cp_new;
  logic [16:0]   dig_sum;
  logic          cp_ok;
  pent_t         fin_ent;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    floor_nxt  = floor_r;
    pend_nxt   = pend_r;
    pidx_nxt   = pidx_r;
    popen_nxt  = popen_r;
    cval_nxt   = cval_r;
    csep_nxt   = csep_r;
    psep_nxt   = psep_r;
    priv_nxt   = priv_r;
    inter_nxt  = inter_r;
    sclass_nxt = sclass_r;
    slen_nxt   = slen_r;
    sover_nxt  = sover_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    extra_nxt  = extra_r;
    otok_nxt   = otok_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r && !out_bus.ready;
    t1v        = 1'b0;
    t2v        = 1'b0;
    disp       = 1'b0;
    t1         = '0;
    t2         = '0;
    mem_we     = 1'b0;
    mem_waddr  = pidx_r[AW-1:0];
    cp_new     = {acc_r[14:0], b[5:0]};
    cp_ok      = (cp_new >= {4'd0, floor_r}) && (cp_new <= tet_pkg::CP_MAX) &&
                 !(cp_new >= tet_pkg::CP_SUR_LO && cp_new <= tet_pkg::CP_SUR_HI);
    dig_sum    = {cval_r, 3'd0} + {2'd0, cval_r, 1'b0} + {13'd0, b[3:0]};
    fin_ent.value = popen_r ? cval_r : 14'd0;
    fin_ent.sep   = popen_r ? csep_r : psep_r;
    mem_wdata  = fin_ent;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (mode_r)
            M_GROUND: begin
              if (pend_r != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                  // Broken sequence: replacement, then the byte on its own.
                  t1v = 1'b1;
                  t1  = tet_pkg::mk_tok(tet_pkg::KIND_GRAPHIC, tet_pkg::CP_REPLACE);
                  t2v = g0_tv;
                  t2  = g0_tok;
                  acc_nxt   = g0_acc;
                  floor_nxt = g0_floor;
                  pend_nxt  = g0_pend;
                  if (g0_esc) begin
                    mode_nxt = M_ESCAPE;
                  end
                end else if (pend_r == 2'd1) begin
                  acc_nxt   = '0;
                  floor_nxt = '0;
                  pend_nxt  = '0;
                  t1 = tet_pkg::mk_tok(tet_pkg::KIND_GRAPHIC,
                                       cp_ok ? cp_new : tet_pkg::CP_REPLACE);
                  t1v = !tet_pkg::is_zero_width(t1.symbol);
                end else begin
                  acc_nxt  = cp_new;
                  pend_nxt = pend_r - 2'd1;
                end
              end else begin
                t1v = g0_tv;
                t1  = g0_tok;
                if (g0_lead) begin
                  acc_nxt   = g0_acc;
                  floor_nxt = g0_floor;
                  pend_nxt  = g0_pend;
                end
                if (g0_esc) begin
                  mode_nxt = M_ESCAPE;
                end
              end
            end
            M_ESCAPE: begin
              mode_nxt = M_GROUND;
              if (b == tet_pkg::B_CSI) begin
                mode_nxt  = M_CSI;
                pidx_nxt  = '0;
                popen_nxt = 1'b0;
                cval_nxt  = '0;
                csep_nxt  = '0;
                psep_nxt  = '0;
                priv_nxt  = '0;
                inter_nxt = '0;
              end else if (b == tet_pkg::B_OSC || b == tet_pkg::B_DCS ||
                           b == tet_pkg::B_SOS || b == tet_pkg::B_PM ||
                           b == tet_pkg::B_APC) begin
                mode_nxt   = M_STRING;
                slen_nxt   = '0;
                sover_nxt  = 1'b0;
                sclass_nxt = (b == tet_pkg::B_OSC) ? tet_pkg::STR_OSC :
                             (b == tet_pkg::B_DCS) ? tet_pkg::STR_DCS :
                             tet_pkg::STR_OTHER;
              end else if (b == tet_pkg::B_G0 || b == tet_pkg::B_G1 ||
                           b == tet_pkg::B_G2 || b == tet_pkg::B_G3) begin
                inter_nxt = b;
                mode_nxt  = M_CHARSET;
              end else if (b == tet_pkg::B_ESC) begin
                mode_nxt = M_ESCAPE;
              end else begin
                t1v = 1'b1;
                t1  = tet_pkg::mk_tok(tet_pkg::KIND_ESC, {13'd0, b});
                if (b == tet_pkg::B_RIS) begin
                  // Full reset of the parser state.
                  pidx_nxt   = '0;
                  popen_nxt  = 1'b0;
                  cval_nxt   = '0;
                  csep_nxt   = '0;
                  psep_nxt   = '0;
                  priv_nxt   = '0;
                  inter_nxt  = '0;
                  acc_nxt    = '0;
                  floor_nxt  = '0;
                  pend_nxt   = '0;
                  sclass_nxt = tet_pkg::STR_NONE;
                  slen_nxt   = '0;
                  sover_nxt  = 1'b0;
                end
              end
            end
            M_CHARSET: begin
              inter_nxt = '0;
              if (b == tet_pkg::B_ESC) begin
                mode_nxt = M_ESCAPE;
              end else begin
                mode_nxt = M_GROUND;
                t1v      = 1'b1;
                t1       = tet_pkg::mk_tok(tet_pkg::KIND_ESC, {13'd0, b});
                t1.inter = inter_r;
              end
            end
            M_CSI: begin
              if (b == tet_pkg::B_ESC) begin
                mode_nxt = M_ESCAPE;
              end else if (b == tet_pkg::B_CAN || b == tet_pkg::B_SUB) begin
                mode_nxt = M_GROUND;
              end else if (b >= tet_pkg::B_ZERO && b <= tet_pkg::B_NINE &&
                           inter_r == 8'd0) begin
                if (!popen_r) begin
                  csep_nxt = psep_r;
                end
                popen_nxt = 1'b1;
                if (pidx_r < IDX_MAX) begin
                  cval_nxt = (dig_sum > {3'd0, tet_pkg::PARAM_SAT}) ?
                             tet_pkg::PARAM_SAT : dig_sum[13:0];
                end
              end else if ((b == tet_pkg::B_SEMI || b == tet_pkg::B_COLON) &&
                           inter_r == 8'd0) begin
                if (pidx_r < IDX_MAX) begin
                  mem_we   = 1'b1;
                  pidx_nxt = pidx_r + 1'b1;
                end
                popen_nxt = 1'b0;
                cval_nxt  = '0;
                psep_nxt  = b;
              end else if (b >= 8'h3c && b <= 8'h3f && pidx_r == '0 && !popen_r &&
                           priv_r == 8'd0 && inter_r == 8'd0) begin
                priv_nxt = b;
              end else if (b >= 8'h20 && b <= 8'h2f) begin
                inter_nxt = (inter_r == 8'd0) ? b : tet_pkg::B_INTERM_ALL;
              end else if (b >= 8'h40 && b <= 8'h7e) begin
                total_nxt = pidx_r;
                if (popen_r || pidx_r != '0) begin
                  popen_nxt = 1'b0;
                  cval_nxt  = '0;
                  if (pidx_r < IDX_MAX) begin
                    mem_we    = 1'b1;
                    // An empty trailing parameter has no separator of its own.
                    mem_wdata.sep = popen_r ? csep_r : 8'd0;
                    pidx_nxt  = pidx_r + 1'b1;
                    total_nxt = pidx_r + 1'b1;
                  end
                end
                disp      = 1'b1;
                t1v       = 1'b1;
                t1        = tet_pkg::mk_tok(tet_pkg::KIND_CSI, {13'd0, b});
                t1.marker = priv_r;
                t1.inter  = inter_r;
                t1.total  = 5'(total_nxt);
                mode_nxt  = M_GROUND;
              end else if (b < 8'h30 || b > 8'h3f) begin
                mode_nxt = M_GROUND;
              end
            end
            M_STRING_ESC: begin
              if (b == tet_pkg::B_ST) begin
                t1v       = 1'b1;
                t1        = tet_pkg::mk_tok(tet_pkg::KIND_STRING, {13'd0, b});
                t1.stype  = sclass_r;
                t1.send   = 1'b1;
                t1.sover  = sover_r;
                sclass_nxt = tet_pkg::STR_NONE;
                slen_nxt   = '0;
                sover_nxt  = 1'b0;
                mode_nxt   = M_GROUND;
              end else if (b != tet_pkg::B_ESC) begin
                mode_nxt = M_STRING;
              end
            end
            M_STRING: begin
              if ((sclass_r == tet_pkg::STR_OSC && b == tet_pkg::B_BEL) ||
                  b == tet_pkg::B_CAN || b == tet_pkg::B_SUB) begin
                t1v       = 1'b1;
                t1        = tet_pkg::mk_tok(tet_pkg::KIND_STRING, {13'd0, b});
                t1.stype  = sclass_r;
                t1.send   = 1'b1;
                t1.sover  = (b == tet_pkg::B_BEL) ? sover_r : 1'b1;
                sclass_nxt = tet_pkg::STR_NONE;
                slen_nxt   = '0;
                sover_nxt  = 1'b0;
                mode_nxt   = M_GROUND;
              end else if (b == tet_pkg::B_ESC) begin
                mode_nxt = M_STRING_ESC;
              end else if (slen_r < LEN_MAX) begin
                t1v      = 1'b1;
                t1       = tet_pkg::mk_tok(tet_pkg::KIND_STRING, {13'd0, b});
                t1.stype = sclass_r;
                slen_nxt = slen_r + 1'b1;
              end else begin
                sover_nxt = 1'b1;
              end
            end
            default: begin
              mode_nxt = M_GROUND;
            end
          endcase

          if (t1v) begin
            ovalid_nxt = 1'b1;
            otok_nxt   = t1;
            olast_nxt  = !t2v && !(disp && total_nxt != '0);
          end
          if (t2v) begin
            extra_nxt = t2;
            state_nxt = S_EXTRA;
          end else if (disp && total_nxt != '0) begin
            cnt_nxt   = '0;
            state_nxt = S_PRD;
          end
        end
      end
      S_EXTRA: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          otok_nxt   = extra_r;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_PRD: begin
        state_nxt = S_PEMIT;
      end
      S_PEMIT: begin
        if (out_free) begin
          ovalid_nxt     = 1'b1;
          otok_nxt       = '0;
          otok_nxt.kind  = tet_pkg::KIND_PARAM;
          otok_nxt.value = rd_data_r.value;
          otok_nxt.sep   = rd_data_r.sep;
          olast_nxt      = (cnt_r + 1'b1 == total_r);
          cnt_nxt        = cnt_r + 1'b1;
          state_nxt      = (cnt_r + 1'b1 == total_r) ? S_IDLE : S_PRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Parameter memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_PRD) begin
      rd_data_r <= mem[cnt_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_GROUND;
      acc_r    <= '0;
      floor_r  <= '0;
      pend_r   <= '0;
      pidx_r   <= '0;
      popen_r  <= 1'b0;
      cval_r   <= '0;
      csep_r   <= '0;
      psep_r   <= '0;
      priv_r   <= '0;
      inter_r  <= '0;
      sclass_r <= tet_pkg::STR_NONE;
      slen_r   <= '0;
      sover_r  <= 1'b0;
      cnt_r    <= '0;
      total_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      floor_r  <= floor_nxt;
      pend_r   <= pend_nxt;
      pidx_r   <= pidx_nxt;
      popen_r  <= popen_nxt;
      cval_r   <= cval_nxt;
      csep_r   <= csep_nxt;
      psep_r   <= psep_nxt;
      priv_r   <= priv_nxt;
      inter_r  <= inter_nxt;
      sclass_r <= sclass_nxt;
      slen_r   <= slen_nxt;
      sover_r  <= sover_nxt;
      cnt_r    <= cnt_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
    end
    extra_r <= extra_nxt;
    otok_r  <= otok_nxt;
    olast_r <= olast_nxt;
  end

  assign out_bus.valid             = ovalid_r;
  assign out_bus.token_kind        = otok_r.kind;
  assign out_bus.symbol            = otok_r.symbol;
  assign out_bus.marker_byte       = otok_r.marker;
  assign out_bus.intermediate_byte = otok_r.inter;
  assign out_bus.param_total       = otok_r.total;
  assign out_bus.param_value       = otok_r.value;
  assign out_bus.param_separator   = otok_r.sep;
  assign out_bus.string_type       = otok_r.stype;
  assign out_bus.string_end        = otok_r.send;
  assign out_bus.string_overflowed = otok_r.sover;
  assign out_bus.last              = olast_r;

  // The parameter count never passes the memory depth.
  a_pidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pidx_r <= IDX_MAX)
    else $error("parameter index beyond capacity");

  // A UTF-8 sequence is only ever open in ground mode.
  a_utf8_ground: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd0 |-> mode_r == M_GROUND)
    else $error("open UTF-8 sequence outside ground mode");

  // A parameter beat is emitted only after its memory read, with no other state between.
  a_param_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PEMIT |-> $past(state_r) == S_PRD || $past(state_r) == S_PEMIT)
    else $error("parameter emitted without a read");

  // The parameter run never reads past the collected count.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRD |-> cnt_r < total_r)
    else $error("parameter read beyond count");

endmodule
